### hw/rtl/gbos_pkg.sv
// Shared constants for the greedy box overlap suppression block.
`default_nettype none

package gbos_pkg;

    // Default sizing of the kept-box store and of one coordinate.
    localparam int MAX_KEPT_DEF    = 256;
    localparam int COORD_WIDTH_DEF = 16;

    // Field widths fixed by the stream format.
    localparam int FIELD_W   = 16;
    localparam int COUNT_W   = 9;
    localparam int THRESH_W  = 17;
    localparam int IOU_SHIFT = 16;

    // Threshold after reset, about 0.45 scaled by 65536.
    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd29491;

    // Input beat: box_index, x_min, y_min, x_max, y_max from the lowest bit up.
    localparam int IN_TDATA_W = 5 * FIELD_W;

    // Output beat: out_index, kept, store_full, kept_count, zero padding.
    localparam int OUT_KEPT_BIT = FIELD_W;
    localparam int OUT_FULL_BIT = FIELD_W + 1;
    localparam int OUT_CNT_LSB  = FIELD_W + 2;
    localparam int OUT_USED_W   = OUT_CNT_LSB + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### hw/rtl/gbos_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gbos_ram #(
    parameter int WIDTH = 4 * gbos_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = gbos_pkg::MAX_KEPT_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read in the same cycle; read data is registered and appears in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/greedy_box_overlap_suppression.sv
// Greedy non-maximum suppression by intersection over union, one candidate at a time.
//
// Candidates arrive on the slave stream, already sorted by descending score:
// tdata carries box_index and the four signed Q2.14 corners, tlast marks the
// last candidate of a set. Each candidate is compared with every box stored so far
// in the set; one decision beat per candidate leaves on the master stream (index,
// kept, store_full, kept count, and tlast as the end-of-set mark). The user writes the
// IoU threshold through i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
//
// After a candidate's beat the block computes its area, reads every stored box,
// waits for the compare pipeline to drain and then offers the decision; the next
// beat is taken once the block is back in idle. The kept boxes are read from the
// store RAM one per cycle and run through a five-stage compare pipeline, so the
// store's single read port sets the rate. A decision waits in an output register;
// the next candidate is taken while it waits, and its own decision is held back
// until that register is free.
// Reset empties the store through its fill count and loads the default
// threshold; no clearing pass is needed. The store empties after the beat
// that carries tlast.
`default_nettype none

module greedy_box_overlap_suppression #(
    parameter int MAX_KEPT    = gbos_pkg::MAX_KEPT_DEF,
    parameter int COORD_WIDTH = gbos_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Threshold register write.
    input  logic                               i_cfg_we,
    input  logic [gbos_pkg::THRESH_W-1:0]      i_cfg_wdata,
    // Candidate stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // box_index, x_min, y_min, x_max, y_max (lowest bit up)
    input  logic [gbos_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // Decision stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_index, kept, store_full, kept_count, zero padding (lowest bit up)
    output logic [gbos_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    import gbos_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int RAW_W  = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int D_W    = CW + 1;
    localparam int P_W    = 2 * D_W;
    localparam int U_W    = P_W + 1;
    localparam int M_W    = U_W + THRESH_W;
    localparam int BOX_W  = 4 * CW;
    localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int PIPE_N = 5;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    // Low COORD_WIDTH bits of a field as a two's complement coordinate.
    function automatic logic signed [CW-1:0] coord_of(input logic [FIELD_W-1:0] raw);
        logic [RAW_W-1:0] wide;
        wide = RAW_W'(raw);
        return wide[CW-1:0];
    endfunction

    // Area of a box, zero when it is inverted.
    function automatic logic signed [P_W-1:0] area_of(
        input logic signed [CW-1:0] lo_x,
        input logic signed [CW-1:0] lo_y,
        input logic signed [CW-1:0] hi_x,
        input logic signed [CW-1:0] hi_y
    );
        logic signed [D_W-1:0] w;
        logic signed [D_W-1:0] h;
        w = D_W'(hi_x) - D_W'(lo_x);
        h = D_W'(hi_y) - D_W'(lo_y);
        if (w < 0 || h < 0) begin
            return '0;
        end
        return w * h;
    endfunction

    // Control state.
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_rd_cnt, n_rd_cnt;
    logic [PIPE_N-1:0]   r_pv, n_pv;
    logic                r_hit, n_hit;
    logic                r_out_vld, n_out_vld;
    logic [THRESH_W-1:0] r_thresh;

    // Candidate held for the whole scan.
    logic [FIELD_W-1:0]    r_cidx;
    logic                  r_clast;
    logic signed [CW-1:0]  r_cx0, r_cy0, r_cx1, r_cy1;
    logic signed [P_W-1:0] r_carea;

    // Compare pipeline.
    logic                  r_s1_ok, r_s1_kinv;
    logic signed [D_W-1:0] r_s1_w, r_s1_h, r_s1_kw, r_s1_kh;
    logic                  r_s2_ok;
    logic signed [P_W-1:0] r_s2_inter, r_s2_karea;
    logic                  r_s3_ok;
    logic signed [P_W-1:0] r_s3_inter;
    logic signed [U_W-1:0] r_s3_uni;
    logic                  r_s4_ok, r_s4_zero, r_s4_pos;
    logic signed [P_W-1:0] r_s4_inter;
    logic [M_W-1:0]        r_s4_prod;

    // Output register.
    logic [FIELD_W-1:0] r_out_idx;
    logic               r_out_kept, r_out_full, r_out_last;
    logic [COUNT_W-1:0] r_out_cnt;

    // Store port and helpers.
    logic                  in_beat, rd_issue, wr_en, finish;
    logic                  keep, full, store;
    logic [CNT_W-1:0]      new_total;
    logic [BOX_W-1:0]      ram_q;
    logic signed [CW-1:0]  bx0, by0, bx1, by1;
    logic signed [CW-1:0]  ix0, iy0, ix1, iy1;
    logic signed [D_W-1:0] iw, ih;
    logic [M_W-1:0]        inter_sc;
    logic                  hit_now;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    // Decision of the current candidate once the pipeline is empty.
    assign keep      = !r_hit;
    assign full      = keep && (r_total == CNT_W'(MAX_KEPT));
    assign store     = keep && !full;
    assign new_total = r_total + CNT_W'(store);

    // Sequencer: take a beat, size the candidate, stream the store, decide.
    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_rd_cnt  = r_rd_cnt;
        n_hit     = r_hit | hit_now;
        n_out_vld = r_out_vld && !i_m_axis_tready;
        rd_issue  = 1'b0;
        finish    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state  = ST_PREP;
                    n_rd_cnt = '0;
                    n_hit    = 1'b0;
                end
            end
            ST_PREP: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_rd_cnt != r_total) begin
                    rd_issue = 1'b1;
                    n_rd_cnt = r_rd_cnt + CNT_W'(1);
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_pv == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    finish    = 1'b1;
                    n_out_vld = 1'b1;
                    n_total   = r_clast ? '0 : new_total;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_pv = {r_pv[PIPE_N-2:0], rd_issue};
    end

    assign wr_en = finish && store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_total   <= '0;
            r_rd_cnt  <= '0;
            r_pv      <= '0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
            r_thresh  <= THRESH_RESET;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_rd_cnt  <= n_rd_cnt;
            r_pv      <= n_pv;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    // Candidate capture and its area.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cidx  <= i_s_axis_tdata[FIELD_W-1:0];
            r_cx0   <= coord_of(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]);
            r_cy0   <= coord_of(i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
            r_cx1   <= coord_of(i_s_axis_tdata[4*FIELD_W-1:3*FIELD_W]);
            r_cy1   <= coord_of(i_s_axis_tdata[5*FIELD_W-1:4*FIELD_W]);
            r_clast <= i_s_axis_tlast;
        end
        if (r_state == ST_PREP) begin
            r_carea <= area_of(r_cx0, r_cy0, r_cx1, r_cy1);
        end
    end

    // Kept-box store.
    gbos_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_KEPT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata ({r_cy1, r_cx1, r_cy0, r_cx0}),
        .i_re    (rd_issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign bx0 = ram_q[CW-1:0];
    assign by0 = ram_q[2*CW-1:CW];
    assign bx1 = ram_q[3*CW-1:2*CW];
    assign by1 = ram_q[4*CW-1:3*CW];

    // Intersection corners; disjoint boxes give a width or height that is not positive.
    assign ix0 = (r_cx0 > bx0) ? r_cx0 : bx0;
    assign iy0 = (r_cy0 > by0) ? r_cy0 : by0;
    assign ix1 = (r_cx1 < bx1) ? r_cx1 : bx1;
    assign iy1 = (r_cy1 < by1) ? r_cy1 : by1;
    assign iw  = D_W'(ix1) - D_W'(ix0);
    assign ih  = D_W'(iy1) - D_W'(iy0);

    // Five compare stages: sizes, products, union, threshold product, compare.
    always_ff @(posedge i_clk) begin
        r_s1_ok   <= (iw > 0) && (ih > 0);
        r_s1_w    <= iw;
        r_s1_h    <= ih;
        r_s1_kw   <= D_W'(bx1) - D_W'(bx0);
        r_s1_kh   <= D_W'(by1) - D_W'(by0);
        r_s1_kinv <= (bx1 < bx0) || (by1 < by0);

        r_s2_ok    <= r_s1_ok;
        r_s2_inter <= r_s1_w * r_s1_h;
        r_s2_karea <= r_s1_kinv ? '0 : r_s1_kw * r_s1_kh;

        r_s3_ok    <= r_s2_ok;
        r_s3_inter <= r_s2_inter;
        r_s3_uni   <= U_W'(r_carea) + U_W'(r_s2_karea) - U_W'(r_s2_inter);

        r_s4_ok    <= r_s3_ok;
        r_s4_inter <= r_s3_inter;
        r_s4_zero  <= (r_s3_uni == '0);
        r_s4_pos   <= !r_s3_uni[U_W-1] && (r_s3_uni != '0);
        r_s4_prod  <= M_W'(r_thresh) * M_W'($unsigned(r_s3_uni));
    end

    // A zero union suppresses when the boxes overlap, a negative one never does.
    assign inter_sc = M_W'($unsigned(r_s4_inter)) << IOU_SHIFT;
    assign hit_now  = r_pv[PIPE_N-1] && r_s4_ok
                      && (r_s4_zero || (r_s4_pos && (inter_sc > r_s4_prod)));

    // Decision register toward the master stream.
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_idx  <= r_cidx;
            r_out_kept <= keep;
            r_out_full <= full;
            r_out_cnt  <= COUNT_W'(new_total);
            r_out_last <= r_clast;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_cnt, r_out_full, r_out_kept, r_out_idx});
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

### hw/rtl/gbos_chk.sv
// Port-level checker for the overlap suppression block, bound to its top level.
`default_nettype none

module gbos_chk (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    input  wire                              o_s_axis_tready,
    input  wire                              o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    input  wire [gbos_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  wire                              o_m_axis_tlast
);

    import gbos_pkg::*;

    logic               in_beat, out_beat;
    logic               kept, full;
    logic [COUNT_W-1:0] cnt;
    logic [1:0]         r_pend;
    logic [COUNT_W-1:0] r_base;

    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat = o_m_axis_tvalid && i_m_axis_tready;
    assign kept     = o_m_axis_tdata[OUT_KEPT_BIT];
    assign full     = o_m_axis_tdata[OUT_FULL_BIT];
    assign cnt      = o_m_axis_tdata[OUT_CNT_LSB +: COUNT_W];

    // Candidates taken but not yet answered, and the count before the next decision.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_base <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_beat) - 2'(out_beat);
            if (out_beat) begin
                r_base <= o_m_axis_tlast ? '0 : cnt;
            end
        end
    end

    // A stalled decision beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("decision beat changed while stalled");

    // Every decision answers a candidate that was taken.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_pend != 2'd0)
        else $error("decision without a pending candidate");

    // Only a surviving box can find the store full.
    a_full_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && full |-> kept)
        else $error("store_full set on a suppressed box");

    // The kept count grows by one exactly when a box is stored, and restarts per set.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> cnt == COUNT_W'(r_base + COUNT_W'(kept && !full)))
        else $error("kept count out of step with decisions");

endmodule

bind greedy_box_overlap_suppression gbos_chk u_gbos_chk (.*);

`default_nettype wire
